// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the entity pool.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AST_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is high.
`define AST_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// File: hdl/epool_pkg.sv
// Types, codes and sizing constants for the dense entity pool.
// No dependencies; design files use it by scoped names, the testbench imports it.
package epool_pkg;

  // Pool sizing
  localparam int CAPACITY = 256;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SLOT_W = 8;
  localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;

  typedef enum logic [1:0] {
    MODE_SPAWN = 2'd0,
    MODE_KILL  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_t;

  // Command word
  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [15:0] health;
    logic [7:0]         kind;
    logic [7:0]         slot;
  } cmd_t;

  // Result word
  typedef struct packed {
    status_t            status;
    logic [7:0]         slot_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [15:0] out_health;
    logic [7:0]         out_kind;
    logic [8:0]         live_count;
  } res_t;

  // One stored entity record
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [15:0] health;
    logic [7:0]         kind;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Source of the record written back to the store
  typedef enum logic [1:0] {
    WSRC_CMD  = 2'd0,
    WSRC_MOVE = 2'd1,
    WSRC_TICK = 2'd2
  } wsrc_t;

  typedef enum logic [2:0] {
    S_IDLE      = 3'd0,
    S_EXEC      = 3'd1,
    S_KILL_MOVE = 3'd2,
    S_READ_OUT  = 3'd3,
    S_TICK_X    = 3'd4,
    S_TICK_Y    = 3'd5
  } state_t;

  // Sequencer to datapath controls
  typedef struct packed {
    wsrc_t           wsrc;
    logic            add_y;
    logic            xs_load;
    logic            res_load;
    status_t         res_status;
    logic [7:0]      res_slot;
    logic            res_rec;
    logic [CW-1:0]   res_count;
  } ctl_t;

  // Record store port controls
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic          re;
    logic [AW-1:0] raddr;
  } ram_ctl_t;

endpackage

// File: hdl/epool_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module epool_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/epool_ctrl.sv
// Sequencer of the entity pool: command latch, live count, tick walk, store control.
// Depends on epool_pkg.
module epool_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  epool_pkg::cmd_t     cmd,
  output logic                busy,
  output epool_pkg::cmd_t     cmd_q,
  output epool_pkg::ctl_t     ctl,
  output epool_pkg::ram_ctl_t ram
);

  epool_pkg::state_t              state, state_next;
  logic [epool_pkg::CW-1:0]       count, count_next;
  logic [epool_pkg::AW-1:0]       idx, idx_next;
  logic [epool_pkg::XW-1:0]       slot_ext;
  logic [epool_pkg::AW-1:0]       slot_addr;
  logic [epool_pkg::CW-1:0]       last;
  logic                           slot_live;
  logic                           slot_is_last;
  logic                           pool_full;
  logic                           walk_end;

  // decode helpers
  assign slot_ext     = epool_pkg::XW'(cmd_q.slot);
  assign slot_addr    = slot_ext[epool_pkg::AW-1:0];
  assign last         = count - epool_pkg::CW'(1);
  assign slot_live    = slot_ext < epool_pkg::XW'(count);
  assign slot_is_last = slot_ext == epool_pkg::XW'(last);
  assign pool_full    = count == epool_pkg::CW'(epool_pkg::CAPACITY);
  assign walk_end     = (epool_pkg::CW'(idx) + epool_pkg::CW'(1)) == count;

  // state, count and walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= epool_pkg::S_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (state == epool_pkg::S_IDLE && start) begin
      cmd_q <= cmd;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      epool_pkg::S_IDLE: begin
        if (start) state_next = epool_pkg::S_EXEC;
      end
      epool_pkg::S_EXEC: begin
        unique case (cmd_q.mode)
          epool_pkg::MODE_SPAWN: state_next = epool_pkg::S_IDLE;
          epool_pkg::MODE_KILL: begin
            state_next = (slot_live && !slot_is_last) ? epool_pkg::S_KILL_MOVE
                                                      : epool_pkg::S_IDLE;
          end
          epool_pkg::MODE_READ: begin
            state_next = slot_live ? epool_pkg::S_READ_OUT : epool_pkg::S_IDLE;
          end
          epool_pkg::MODE_TICK: begin
            state_next = (count != '0) ? epool_pkg::S_TICK_X : epool_pkg::S_IDLE;
          end
          default: state_next = epool_pkg::S_IDLE;
        endcase
      end
      epool_pkg::S_KILL_MOVE: state_next = epool_pkg::S_IDLE;
      epool_pkg::S_READ_OUT:  state_next = epool_pkg::S_IDLE;
      epool_pkg::S_TICK_X:    state_next = epool_pkg::S_TICK_Y;
      epool_pkg::S_TICK_Y: begin
        state_next = walk_end ? epool_pkg::S_IDLE : epool_pkg::S_TICK_X;
      end
      default: state_next = epool_pkg::S_IDLE;
    endcase
  end

  // outputs, store controls and counter updates
  always_comb begin
    busy           = state != epool_pkg::S_IDLE;
    count_next     = count;
    idx_next       = idx;
    ram            = '0;
    ctl.wsrc       = epool_pkg::WSRC_CMD;
    ctl.add_y      = 1'b0;
    ctl.xs_load    = 1'b0;
    ctl.res_load   = 1'b0;
    ctl.res_status = epool_pkg::ST_OK;
    ctl.res_slot   = '0;
    ctl.res_rec    = 1'b0;
    unique case (state)
      epool_pkg::S_IDLE: begin
      end
      epool_pkg::S_EXEC: begin
        unique case (cmd_q.mode)
          epool_pkg::MODE_SPAWN: begin
            ctl.res_load = 1'b1;
            if (pool_full) begin
              ctl.res_status = epool_pkg::ST_FULL;
            end else begin
              // append at the end of the dense range
              ram.we       = 1'b1;
              ram.waddr    = count[epool_pkg::AW-1:0];
              ctl.wsrc     = epool_pkg::WSRC_CMD;
              count_next   = count + epool_pkg::CW'(1);
              ctl.res_slot = 8'(count);
            end
          end
          epool_pkg::MODE_KILL: begin
            ctl.res_slot = cmd_q.slot;
            if (!slot_live) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = epool_pkg::ST_NOT_LIVE;
            end else if (slot_is_last) begin
              ctl.res_load = 1'b1;
              count_next   = last;
            end else begin
              // fetch the last record to fill the hole
              ram.re    = 1'b1;
              ram.raddr = last[epool_pkg::AW-1:0];
            end
          end
          epool_pkg::MODE_READ: begin
            ctl.res_slot = cmd_q.slot;
            if (!slot_live) begin
              ctl.res_load   = 1'b1;
              ctl.res_status = epool_pkg::ST_NOT_LIVE;
            end else begin
              ram.re    = 1'b1;
              ram.raddr = slot_addr;
            end
          end
          epool_pkg::MODE_TICK: begin
            if (count == '0) begin
              ctl.res_load = 1'b1;
            end else begin
              ram.re    = 1'b1;
              ram.raddr = '0;
              idx_next  = '0;
            end
          end
          default: begin
          end
        endcase
      end
      epool_pkg::S_KILL_MOVE: begin
        ram.we       = 1'b1;
        ram.waddr    = slot_addr;
        ctl.wsrc     = epool_pkg::WSRC_MOVE;
        count_next   = last;
        ctl.res_load = 1'b1;
        ctl.res_slot = cmd_q.slot;
      end
      epool_pkg::S_READ_OUT: begin
        ctl.res_load = 1'b1;
        ctl.res_slot = cmd_q.slot;
        ctl.res_rec  = 1'b1;
      end
      epool_pkg::S_TICK_X: begin
        ctl.add_y   = 1'b0;
        ctl.xs_load = 1'b1;
      end
      epool_pkg::S_TICK_Y: begin
        // write back this slot, prefetch the next one
        ctl.add_y = 1'b1;
        ram.we    = 1'b1;
        ram.waddr = idx;
        ctl.wsrc  = epool_pkg::WSRC_TICK;
        if (walk_end) begin
          ctl.res_load = 1'b1;
        end else begin
          ram.re    = 1'b1;
          ram.raddr = idx + epool_pkg::AW'(1);
          idx_next  = idx + epool_pkg::AW'(1);
        end
      end
      default: begin
      end
    endcase
    ctl.res_count = count_next;
  end

endmodule

// File: hdl/epool_dp.sv
// Datapath of the entity pool: shared 32-bit adder, write-back mux, result register.
// Depends on epool_pkg.
module epool_dp (
  input  logic              clk,
  input  logic              rst,
  input  epool_pkg::ctl_t   ctl,
  input  epool_pkg::cmd_t   cmd_q,
  input  epool_pkg::rec_t   rd_rec,
  output epool_pkg::rec_t   wr_rec,
  output logic              done,
  output epool_pkg::res_t   result
);

  logic signed [31:0] add_a, add_b, sum;
  logic signed [31:0] xs;

  // shared adder: x lane then y lane, wraps in two's complement
  assign add_a = ctl.add_y ? rd_rec.pos_y : rd_rec.pos_x;
  assign add_b = ctl.add_y ? rd_rec.vel_y : rd_rec.vel_x;
  assign sum   = add_a + add_b;

  // new x held until the y lane is done
  always_ff @(posedge clk) begin
    if (ctl.xs_load) begin
      xs <= sum;
    end
  end

  // record written back to the store
  always_comb begin
    case (ctl.wsrc)
      epool_pkg::WSRC_CMD: begin
        wr_rec.pos_x  = cmd_q.pos_x;
        wr_rec.pos_y  = cmd_q.pos_y;
        wr_rec.vel_x  = cmd_q.vel_x;
        wr_rec.vel_y  = cmd_q.vel_y;
        wr_rec.health = cmd_q.health;
        wr_rec.kind   = cmd_q.kind;
      end
      epool_pkg::WSRC_TICK: begin
        wr_rec       = rd_rec;
        wr_rec.pos_x = xs;
        wr_rec.pos_y = sum;
      end
      default: wr_rec = rd_rec;
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.res_load;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      result.status     <= ctl.res_status;
      result.slot_index <= ctl.res_slot;
      result.out_pos_x  <= ctl.res_rec ? rd_rec.pos_x : '0;
      result.out_pos_y  <= ctl.res_rec ? rd_rec.pos_y : '0;
      result.out_vel_x  <= ctl.res_rec ? rd_rec.vel_x : '0;
      result.out_vel_y  <= ctl.res_rec ? rd_rec.vel_y : '0;
      result.out_health <= ctl.res_rec ? rd_rec.health : '0;
      result.out_kind   <= ctl.res_rec ? rd_rec.kind : '0;
      result.live_count <= 9'(ctl.res_count);
    end
  end

endmodule

// File: hdl/dense_entity_pool_with_motion_tick.sv
// Top level of the dense entity pool with swap-remove and motion tick.
// Depends on epool_pkg, epool_ram, epool_ctrl and epool_dp.
//
// Use: drive a command word on cmd and raise start; it is taken at a rising
// edge where start is high and busy is low. Modes are spawn, kill, motion
// tick and read slot. Every command gives exactly one result word on result,
// valid for the single cycle in which done is high; the receiver cannot
// stall, so it must take the word in that cycle.
// Live records always occupy slots 0 .. live_count-1. All records sit in one
// record RAM with a registered read port, and ticks run through one shared
// 32-bit adder, x lane then y lane.
// Steps from accept to done: spawn writes the new record; kill of the last
// slot or of a bad slot answers directly, else the last record is read and
// moved into the hole; read of a bad slot answers directly, else the record
// is read; tick reads each live record, adds x, then adds y and writes back.
// busy drops in the done cycle, so the next command can be taken there.
// Reset (rst, synchronous) empties the pool and clears done; record contents
// are not cleared and need no clearing pass.
module dense_entity_pool_with_motion_tick (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  epool_pkg::cmd_t cmd,
  output logic            busy,
  output logic            done,
  output epool_pkg::res_t result
);

  epool_pkg::cmd_t            cmd_q;
  epool_pkg::ctl_t            ctl;
  epool_pkg::ram_ctl_t        ram;
  epool_pkg::rec_t            rd_rec;
  epool_pkg::rec_t            wr_rec;
  logic [epool_pkg::REC_W-1:0] rd_raw;

  // sequencer
  epool_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .cmd_q (cmd_q),
    .ctl   (ctl),
    .ram   (ram)
  );

  // record store
  epool_ram #(
    .WIDTH (epool_pkg::REC_W),
    .DEPTH (epool_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (wr_rec),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rd_raw)
  );

  assign rd_rec = epool_pkg::rec_t'(rd_raw);

  // adder, write-back and result
  epool_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .cmd_q  (cmd_q),
    .rd_rec (rd_rec),
    .wr_rec (wr_rec),
    .done   (done),
    .result (result)
  );

endmodule

// File: hdl/epool_chk.sv
// Port-level checker for the entity pool, bound to the top level.
// Depends on epool_pkg and assert_macros.svh.
`include "assert_macros.svh"

module epool_chk (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input epool_pkg::res_t result
);

  logic rep_full;
  logic rep_not_live;
  logic full_ok;
  logic slot_past_end;

  // report decode
  assign rep_full      = done && (result.status == epool_pkg::ST_FULL);
  assign rep_not_live  = done && (result.status == epool_pkg::ST_NOT_LIVE);
  assign full_ok       = (result.live_count == 9'(epool_pkg::CAPACITY)) &&
                         (result.slot_index == '0);
  assign slot_past_end = 9'(result.slot_index) >= result.live_count;

  // a taken command keeps the block busy in the next cycle
  `AST_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // results only appear once the sequencer is back to idle
  `AST_IMPL(a_done_idle, clk, rst, done, !busy)

  // no two results in consecutive cycles
  `AST_NEXT(a_done_gap, clk, rst, done, !done)

  // a full report means the pool is at capacity and names no slot
  `AST_IMPL(a_full_count, clk, rst, rep_full, full_ok)

  // a not-live report names a slot at or past the live count
  `AST_IMPL(a_not_live_slot, clk, rst, rep_not_live, slot_past_end)

endmodule

bind dense_entity_pool_with_motion_tick epool_chk u_chk (.*);

// File: tb/sv/dense_entity_pool_with_motion_tick_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the dense entity pool with motion tick.
// Depends on epool_pkg and the dense_entity_pool_with_motion_tick top level.
module dense_entity_pool_with_motion_tick_test;
  import epool_pkg::*;

  localparam int LIMIT = 2_000_000;

  logic clk;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic done;
  res_t result;

  dense_entity_pool_with_motion_tick uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the pool; live records sit in 0 .. shadow_count-1
  rec_t        shadow_rec [CAPACITY];
  int unsigned shadow_count;

  res_t due_results[$];
  int   errors;
  int   cycles;
  int   items;
  int   n_spawn, n_kill, n_tick, n_read, n_full, n_not_live, n_moves, peak_count;

  // Directed rows; a typed row carries its own expected result word
  typedef struct {
    cmd_t c;
    bit   typed;
    res_t r;
  } row_t;
  row_t plan[$];

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ERROR %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  // Work out the result word of one command and update the shadow pool
  function automatic res_t predict_pool_result(cmd_t c);
    res_t        r;
    int unsigned last;
    r = '0;
    r.status = ST_OK;
    case (c.mode)
      MODE_SPAWN: begin
        n_spawn++;
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          shadow_rec[shadow_count] = '{c.pos_x, c.pos_y, c.vel_x, c.vel_y, c.health, c.kind};
          r.slot_index = 8'(shadow_count);
          shadow_count++;
        end
      end
      MODE_KILL: begin
        n_kill++;
        r.slot_index = c.slot;
        if (c.slot >= shadow_count) begin
          r.status = ST_NOT_LIVE;
          n_not_live++;
        end else begin
          // swap-remove: last record fills the hole
          last = shadow_count - 1;
          if (c.slot != last) begin
            shadow_rec[c.slot] = shadow_rec[last];
            n_moves++;
          end
          shadow_count = last;
        end
      end
      MODE_TICK: begin
        n_tick++;
        for (int i = 0; i < shadow_count; i++) begin
          shadow_rec[i].pos_x = shadow_rec[i].pos_x + shadow_rec[i].vel_x;
          shadow_rec[i].pos_y = shadow_rec[i].pos_y + shadow_rec[i].vel_y;
        end
      end
      default: begin
        n_read++;
        r.slot_index = c.slot;
        if (c.slot >= shadow_count) begin
          r.status = ST_NOT_LIVE;
          n_not_live++;
        end else begin
          r.out_pos_x  = shadow_rec[c.slot].pos_x;
          r.out_pos_y  = shadow_rec[c.slot].pos_y;
          r.out_vel_x  = shadow_rec[c.slot].vel_x;
          r.out_vel_y  = shadow_rec[c.slot].vel_y;
          r.out_health = shadow_rec[c.slot].health;
          r.out_kind   = shadow_rec[c.slot].kind;
        end
      end
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
    r.live_count = 9'(shadow_count);
    return r;
  endfunction

  task automatic check_result(res_t got, res_t want);
    if (got.status !== want.status) report("status", got.status, want.status);
    if (got.slot_index !== want.slot_index)
      report("slot_index", got.slot_index, want.slot_index);
    if (got.out_pos_x !== want.out_pos_x) report("out_pos_x", got.out_pos_x, want.out_pos_x);
    if (got.out_pos_y !== want.out_pos_y) report("out_pos_y", got.out_pos_y, want.out_pos_y);
    if (got.out_vel_x !== want.out_vel_x) report("out_vel_x", got.out_vel_x, want.out_vel_x);
    if (got.out_vel_y !== want.out_vel_y) report("out_vel_y", got.out_vel_y, want.out_vel_y);
    if (got.out_health !== want.out_health)
      report("out_health", got.out_health, want.out_health);
    if (got.out_kind !== want.out_kind) report("out_kind", got.out_kind, want.out_kind);
    if (got.live_count !== want.live_count)
      report("live_count", got.live_count, want.live_count);
  endtask

  // Result monitor: done marks a word valid for exactly one cycle
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (due_results.size() == 0)
        report("result word with nothing due", 64'(result.live_count), '0);
      else check_result(result, due_results.pop_front());
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("dense_entity_pool_with_motion_tick_test: done, errors");
      $finish;
    end
  end

  // Corner values turn up now and then in random data
  function automatic logic [31:0] rand_word();
    logic [31:0] corners [4];
    corners = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
    if ($urandom_range(99) < 10) return corners[$urandom_range(3)];
    return $urandom;
  endfunction

  // Random command word; kill and read name a live slot most of the time
  function automatic cmd_t rand_cmd(mode_t m);
    cmd_t c;
    c.mode   = m;
    c.pos_x  = rand_word();
    c.pos_y  = rand_word();
    c.vel_x  = rand_word();
    c.vel_y  = rand_word();
    c.health = 16'($urandom);
    c.kind   = 8'($urandom);
    if (shadow_count > 0 && $urandom_range(99) < 85)
      c.slot = 8'($urandom_range(shadow_count - 1, 0));
    else
      c.slot = 8'($urandom);
    return c;
  endfunction

  function automatic mode_t pick_mode(int w_spawn, int w_kill, int w_tick);
    int r;
    r = $urandom_range(99);
    if (r < w_spawn) return MODE_SPAWN;
    if (r < w_spawn + w_kill) return MODE_KILL;
    if (r < w_spawn + w_kill + w_tick) return MODE_TICK;
    return MODE_READ;
  endfunction

  function automatic void add_row(mode_t m, logic [31:0] px, py, vx, vy, logic [15:0] h,
                                  logic [7:0] k, s, bit typed, status_t st,
                                  logic [7:0] si, logic [8:0] cnt);
    row_t row;
    row.c = '{m, px, py, vx, vy, h, k, s};
    row.typed = typed;
    row.r = '0;
    row.r.status = st;
    row.r.slot_index = si;
    row.r.live_count = cnt;
    plan.push_back(row);
  endfunction

  // Present one command word and hold it until taken
  task automatic issue(cmd_t c, bit typed, res_t want);
    res_t pred;
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pred = predict_pool_result(c);
    due_results.push_back(typed ? want : pred);
    items++;
  endtask

  // Sender gap with junk on the command bus
  task automatic pace(int idle_pct);
    int n;
    if ($urandom_range(99) < idle_pct) begin
      n = $urandom_range(1, 6);
      start <= 1'b0;
      cmd   <= rand_cmd(mode_t'($urandom_range(3)));
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold off until every due result word is back
  task automatic drain();
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int n, int w_spawn, int w_kill, int w_tick, int idle_pct);
    for (int i = 0; i < n; i++) begin
      issue(rand_cmd(pick_mode(w_spawn, w_kill, w_tick)), 1'b0, '0);
      pace(idle_pct);
    end
  endtask

  initial begin
    cmd_t c;
    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    shadow_count = 0;

    // Empty pool, extremes, wrap, swap-remove and last-slot kill
    add_row(MODE_READ, 0, 0, 0, 0, 0, 0, 8'd0, 1, ST_NOT_LIVE, 8'd0, 9'd0);
    add_row(MODE_KILL, 0, 0, 0, 0, 0, 0, 8'd255, 1, ST_NOT_LIVE, 8'd255, 9'd0);
    add_row(MODE_TICK, 0, 0, 0, 0, 0, 0, 8'd0, 1, ST_OK, 8'd0, 9'd0);
    add_row(MODE_SPAWN, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff, 16'h7fff,
            8'hff, 8'hff, 1, ST_OK, 8'd0, 9'd1);
    add_row(MODE_SPAWN, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            16'h8000, 8'h00, 8'h00, 1, ST_OK, 8'd1, 9'd2);
    add_row(MODE_SPAWN, 0, 0, 0, 0, 0, 8'h3c, 8'd7, 1, ST_OK, 8'd2, 9'd3);
    add_row(MODE_READ, 0, 0, 0, 0, 0, 0, 8'd0, 0, ST_OK, 8'd0, 9'd0);
    add_row(MODE_READ, 0, 0, 0, 0, 0, 0, 8'd1, 0, ST_OK, 8'd0, 9'd0);
    add_row(MODE_TICK, 0, 0, 0, 0, 0, 0, 8'd0, 1, ST_OK, 8'd0, 9'd3);
    add_row(MODE_READ, 0, 0, 0, 0, 0, 0, 8'd0, 0, ST_OK, 8'd0, 9'd0);
    add_row(MODE_READ, 0, 0, 0, 0, 0, 0, 8'd1, 0, ST_OK, 8'd0, 9'd0);
    add_row(MODE_READ, 0, 0, 0, 0, 0, 0, 8'd3, 1, ST_NOT_LIVE, 8'd3, 9'd3);
    add_row(MODE_KILL, 0, 0, 0, 0, 0, 0, 8'd0, 1, ST_OK, 8'd0, 9'd2);
    add_row(MODE_READ, 0, 0, 0, 0, 0, 0, 8'd0, 0, ST_OK, 8'd0, 9'd0);
    add_row(MODE_KILL, 0, 0, 0, 0, 0, 0, 8'd1, 1, ST_OK, 8'd1, 9'd1);
    add_row(MODE_KILL, 0, 0, 0, 0, 0, 0, 8'd1, 1, ST_NOT_LIVE, 8'd1, 9'd1);
    add_row(MODE_READ, 0, 0, 0, 0, 0, 0, 8'd1, 1, ST_NOT_LIVE, 8'd1, 9'd1);
    add_row(MODE_READ, 0, 0, 0, 0, 0, 0, 8'd0, 0, ST_OK, 8'd0, 9'd0);
    add_row(MODE_KILL, 0, 0, 0, 0, 0, 0, 8'd0, 1, ST_OK, 8'd0, 9'd0);
    add_row(MODE_SPAWN, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 32'hffff_fffe, 32'h2, 16'h8001,
            8'h81, 8'd0, 1, ST_OK, 8'd0, 9'd1);
    add_row(MODE_TICK, 0, 0, 0, 0, 0, 0, 8'd0, 1, ST_OK, 8'd0, 9'd1);
    add_row(MODE_READ, 0, 0, 0, 0, 0, 0, 8'd0, 0, ST_OK, 8'd0, 9'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      issue(plan[i].c, plan[i].typed, plan[i].r);
      pace(36);
    end
    drain();

    // Fill the pool, hit full, then work at the top slot
    while (shadow_count < CAPACITY) begin
      issue(rand_cmd(MODE_SPAWN), 1'b0, '0);
      pace(36);
    end
    repeat (2) issue(rand_cmd(MODE_SPAWN), 1'b0, '0);
    issue(rand_cmd(MODE_TICK), 1'b0, '0);
    foreach (plan[i]) begin
      if (i < 6) begin
        c = rand_cmd(i == 0 ? MODE_READ : i == 1 ? MODE_KILL : i == 2 ? MODE_READ :
                     i == 3 ? MODE_SPAWN : i == 4 ? MODE_KILL : MODE_READ);
        c.slot = (i < 3) ? 8'd255 : 8'd0;
        issue(c, 1'b0, '0);
      end
    end
    drain();

    // Random traffic; sender idles 36%, then 66%, then not at all
    run_phase(100, 40, 20, 10, 36);
    drain();
    run_phase(100, 10, 60, 10, 66);
    drain();
    run_phase(80, 35, 30, 10, 0);
    drain();
    repeat (8) @(posedge clk);

    $display("%0d command words: %0d spawn (%0d full), %0d kill (%0d moves), %0d tick, %0d read",
             items, n_spawn, n_full, n_kill, n_moves, n_tick, n_read);
    $display("%0d not-live slot hits, pool peaked at %0d records, %0d mismatches",
             n_not_live, peak_count, errors);
    if (errors == 0)
      $display("dense_entity_pool_with_motion_tick_test: done, clean");
    else
      $display("dense_entity_pool_with_motion_tick_test: done, errors");
    $finish;
  end

endmodule
